FILE: src/i2ctbe_pkg.sv
// Shared constants and beat types for the I2C target bit engine.
package i2ctbe_pkg;

	localparam int unsigned RX_DEPTH_DEF = 256;
	localparam int unsigned TX_DEPTH_DEF = 256;

	localparam int unsigned PHASE_W = 3;
	localparam int unsigned BCNT_W  = 4;
	localparam int unsigned ADDR_W  = 7;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned IDX_W   = 8;

	localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ADDR     = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ADDR_ACK = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RX_DATA  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RX_ACK   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_TX_DATA  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_WAIT_ACK = 3'd6;

	localparam logic MODE_SCL = 1'b0;
	localparam logic MODE_SDA = 1'b1;

	localparam logic [BCNT_W-1:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic              mode;
		logic              scl;
		logic              sda;
		logic [BYTE_W-1:0] tx_byte;
	} evt_beat_t;

	typedef struct packed {
		logic               sda_drive;
		logic               sda_level;
		logic               rx_valid;
		logic [BYTE_W-1:0]  rx_byte;
		logic [IDX_W-1:0]   rx_index;
		logic               rx_overflow;
		logic [IDX_W-1:0]   tx_index;
		logic [PHASE_W-1:0] bus_state;
	} res_beat_t;

endpackage

FILE: src/i2ctbe_if.sv
// Valid/ready channel interfaces for line-edge beats and result beats.
interface i2ctbe_evt_if;
	import i2ctbe_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic              scl;
	logic              sda;
	logic [BYTE_W-1:0] tx_byte;

	modport source (output valid, output mode, output scl, output sda, output tx_byte,
		input ready);
	modport sink (input valid, input mode, input scl, input sda, input tx_byte,
		output ready);
endinterface

interface i2ctbe_res_if;
	import i2ctbe_pkg::*;

	logic               valid;
	logic               ready;
	logic               sda_drive;
	logic               sda_level;
	logic               rx_valid;
	logic [BYTE_W-1:0]  rx_byte;
	logic [IDX_W-1:0]   rx_index;
	logic               rx_overflow;
	logic [IDX_W-1:0]   tx_index;
	logic [PHASE_W-1:0] bus_state;

	modport source (output valid, output sda_drive, output sda_level, output rx_valid,
		output rx_byte, output rx_index, output rx_overflow, output tx_index,
		output bus_state, input ready);
	modport sink (input valid, input sda_drive, input sda_level, input rx_valid,
		input rx_byte, input rx_index, input rx_overflow, input tx_index,
		input bus_state, output ready);
endinterface

FILE: src/i2ctbe_core.sv
// Bus state registers and single-pass next-state logic for one line-edge beat.
module i2ctbe_core #(
	parameter int unsigned RX_DEPTH = i2ctbe_pkg::RX_DEPTH_DEF,
	parameter int unsigned TX_DEPTH = i2ctbe_pkg::TX_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [i2ctbe_pkg::ADDR_W-1:0]        cfg_wdata,
	input  logic                                 fire,
	input  i2ctbe_pkg::evt_beat_t                evt,
	output i2ctbe_pkg::res_beat_t                res
);
	import i2ctbe_pkg::*;

	localparam int unsigned RXC_W = $clog2(RX_DEPTH + 1);
	localparam int unsigned TXP_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam logic [RXC_W-1:0] RXC_FULL = RXC_W'(RX_DEPTH);
	localparam logic [TXP_W-1:0] TXP_LAST = TXP_W'(TX_DEPTH - 1);

	logic [ADDR_W-1:0]  own_address_q;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
	logic [BYTE_W-1:0]  rx_shift_q, rx_shift_d;
	logic               rd_req_q, rd_req_d;
	logic [RXC_W-1:0]   rx_count_q, rx_count_d;
	logic [TXP_W-1:0]   tx_ptr_q, tx_ptr_d;
	logic [BYTE_W-1:0]  tx_shift_q, tx_shift_d;
	logic               sda_oe_q, sda_oe_d;
	logic               sda_val_q, sda_val_d;
	logic               rx_valid, rx_over;
	logic [BYTE_W-1:0]  rx_byte;
	logic [IDX_W-1:0]   rx_index;

	always_comb begin
		phase_d    = phase_q;
		bcnt_d     = bcnt_q;
		rx_shift_d = rx_shift_q;
		rd_req_d   = rd_req_q;
		rx_count_d = rx_count_q;
		tx_ptr_d   = tx_ptr_q;
		tx_shift_d = tx_shift_q;
		sda_oe_d   = sda_oe_q;
		sda_val_d  = sda_val_q;
		rx_valid   = 1'b0;
		rx_over    = 1'b0;
		rx_byte    = '0;
		rx_index   = '0;
		if (evt.mode == MODE_SDA) begin
			if (evt.scl) begin
				if (!evt.sda) begin
					if (phase_q == PH_IDLE || phase_q == PH_RX_DATA) begin
						if (phase_q == PH_IDLE) begin
							rx_count_d = '0;
						end
						bcnt_d     = '0;
						rx_shift_d = '0;
						phase_d    = PH_ADDR;
					end
				end else begin
					phase_d  = PH_IDLE;
					sda_oe_d = 1'b0;
				end
			end
		end else if (evt.scl) begin
			if (phase_q == PH_ADDR || phase_q == PH_RX_DATA) begin
				if (bcnt_q < BITS_PER_BYTE) begin
					rx_shift_d = {rx_shift_q[BYTE_W-2:0], evt.sda};
					bcnt_d     = bcnt_q + 1'b1;
				end
			end else if (phase_q == PH_WAIT_ACK) begin
				phase_d = evt.sda ? PH_IDLE : PH_TX_DATA;
			end
		end else begin
			unique case (phase_q)
				PH_TX_DATA: begin
					if (bcnt_q < BITS_PER_BYTE) begin
						if (bcnt_q == '0) begin
							tx_shift_d = evt.tx_byte;
						end
						sda_oe_d  = 1'b1;
						sda_val_d = tx_shift_d[~bcnt_q[2:0]];
						bcnt_d    = bcnt_q + 1'b1;
					end else begin
						sda_oe_d = 1'b0;
						bcnt_d   = '0;
						tx_ptr_d = (tx_ptr_q == TXP_LAST) ? '0 : tx_ptr_q + 1'b1;
						phase_d  = PH_WAIT_ACK;
					end
				end
				PH_ADDR: begin
					if (bcnt_q >= BITS_PER_BYTE) begin
						if (rx_shift_q[BYTE_W-1:1] == own_address_q) begin
							sda_oe_d  = 1'b1;
							sda_val_d = 1'b0;
							rd_req_d  = rx_shift_q[0];
							phase_d   = PH_ADDR_ACK;
						end else begin
							phase_d = PH_IDLE;
						end
						bcnt_d     = '0;
						rx_shift_d = '0;
					end
				end
				PH_RX_DATA: begin
					if (bcnt_q >= BITS_PER_BYTE) begin
						sda_oe_d  = 1'b1;
						sda_val_d = 1'b0;
						rx_valid  = 1'b1;
						rx_byte   = rx_shift_q;
						if (rx_count_q >= RXC_FULL) begin
							rx_over = 1'b1;
						end else begin
							rx_index   = IDX_W'(rx_count_q);
							rx_count_d = rx_count_q + 1'b1;
						end
						bcnt_d     = '0;
						rx_shift_d = '0;
						phase_d    = PH_RX_ACK;
					end
				end
				PH_ADDR_ACK: begin
					if (rd_req_q) begin
						tx_ptr_d   = '0;
						tx_shift_d = evt.tx_byte;
						sda_oe_d   = 1'b1;
						sda_val_d  = evt.tx_byte[BYTE_W-1];
						bcnt_d     = 4'd1;
						phase_d    = PH_TX_DATA;
					end else begin
						sda_oe_d = 1'b0;
						phase_d  = PH_RX_DATA;
					end
				end
				PH_RX_ACK: begin
					sda_oe_d = 1'b0;
					phase_d  = PH_RX_DATA;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.sda_drive   = sda_oe_d;
		res.sda_level   = sda_val_d;
		res.rx_valid    = rx_valid;
		res.rx_byte     = rx_byte;
		res.rx_index    = rx_index;
		res.rx_overflow = rx_over;
		res.tx_index    = IDX_W'(tx_ptr_d);
		res.bus_state   = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (cfg_wen) begin
			own_address_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bcnt_q     <= '0;
			rx_shift_q <= '0;
			rd_req_q   <= 1'b0;
			rx_count_q <= '0;
			tx_ptr_q   <= '0;
			tx_shift_q <= '0;
			sda_oe_q   <= 1'b0;
			sda_val_q  <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_d;
			bcnt_q     <= bcnt_d;
			rx_shift_q <= rx_shift_d;
			rd_req_q   <= rd_req_d;
			rx_count_q <= rx_count_d;
			tx_ptr_q   <= tx_ptr_d;
			tx_shift_q <= tx_shift_d;
			sda_oe_q   <= sda_oe_d;
			sda_val_q  <= sda_val_d;
		end
	end

`ifndef ASSERT_OFF
	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= BITS_PER_BYTE)
		else $error("bit count beyond a byte");
	a_rx_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= RXC_FULL)
		else $error("receive count beyond depth");
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_WAIT_ACK)
		else $error("bus phase outside the known codes");
`endif
endmodule

FILE: src/i2ctbe_outbuf.sv
// Result register with skid stage between the engine and the result channel.
module i2ctbe_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  i2ctbe_pkg::res_beat_t din,
	output logic                  in_ready,
	i2ctbe_res_if.source          res
);
	import i2ctbe_pkg::*;

	res_beat_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;
	logic      pop;

	assign pop      = out_valid_q && res.ready;
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= din;
			end else begin
				out_q <= din;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.sda_drive   = out_q.sda_drive;
	assign res.sda_level   = out_q.sda_level;
	assign res.rx_valid    = out_q.rx_valid;
	assign res.rx_byte     = out_q.rx_byte;
	assign res.rx_index    = out_q.rx_index;
	assign res.rx_overflow = out_q.rx_overflow;
	assign res.tx_index    = out_q.tx_index;
	assign res.bus_state   = out_q.bus_state;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat with the output stage empty");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && pop) |=> (out_valid_q && !skid_valid_q))
		else $error("skid beat lost on drain");
	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && in_ready && out_valid_q && !pop) |=> skid_valid_q)
		else $error("beat accepted under stall not held");
`endif
endmodule

FILE: src/i2c_target_bit_engine.sv
// Each accepted line-edge beat's result is registered in the output or skid stage.
// Throughput: one line-edge beat per cycle while the skid is empty; state updates in
// a single registered pass; the two-deep buffer keeps input ready as a stall begins.
// Reset: arst_n clears bus state, counters, SDA drive and own_address to zero.
// Reset leaves the result channel empty; no clearing pass is needed.
module i2c_target_bit_engine #(
	parameter int unsigned RX_DEPTH = i2ctbe_pkg::RX_DEPTH_DEF,
	parameter int unsigned TX_DEPTH = i2ctbe_pkg::TX_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [i2ctbe_pkg::ADDR_W-1:0] cfg_wdata,
	i2ctbe_evt_if.sink                    evt,
	i2ctbe_res_if.source                  res
);
	import i2ctbe_pkg::*;

	evt_beat_t evt_beat;
	res_beat_t res_beat;
	logic      fire;
	logic      buf_ready;

	assign evt_beat  = '{mode: evt.mode, scl: evt.scl, sda: evt.sda, tx_byte: evt.tx_byte};
	assign evt.ready = buf_ready;
	assign fire      = evt.valid && buf_ready;

	i2ctbe_core #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.evt       (evt_beat),
		.res       (res_beat)
	);

	i2ctbe_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.din      (res_beat),
		.in_ready (buf_ready),
		.res      (res)
	);
endmodule
